### design/lpg_pkg.sv
package lpg_pkg;

  localparam int COORD_BITS = 12;
  // decision and step terms carry the doubled zone-0 deltas plus sign headroom
  localparam int DEC_W  = COORD_BITS + 4;
  localparam int STEP_W = COORD_BITS + 3;

  localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [2:0] ZONE_0 = 3'd0;
  localparam logic [2:0] ZONE_1 = 3'd1;
  localparam logic [2:0] ZONE_2 = 3'd2;
  localparam logic [2:0] ZONE_3 = 3'd3;
  localparam logic [2:0] ZONE_4 = 3'd4;
  localparam logic [2:0] ZONE_5 = 3'd5;
  localparam logic [2:0] ZONE_6 = 3'd6;
  localparam logic [2:0] ZONE_7 = 3'd7;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   wcoord_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last;
  } pixel_t;

endpackage

### design/line_pixel_generator.sv
// line_pixel_generator: eight-octant midpoint line rasterizer
//
// input stream: in_tuser selects the word kind (0 = load endpoints,
// 1 = step). a load word carries both endpoints in in_tdata, gives no
// output word and replaces any line in progress. each step word gives one
// output word with the next pixel of the line, in true orientation, and
// out_tlast high on the end point. a step with no line loaded gives nothing.
//
// the pixel of a step word is registered in the output register (or the
// skid register on a stall). throughput: one word per cycle while in_tready
// is high, set by the decision update (one add and one compare per pixel).
//
// an output register plus one skid register sit on the result side, so
// in_tready stays high for one more word when out_tready drops; it falls
// only once the skid register holds a pixel, and rises again the cycle
// after out_tready returns.
//
// reset (rst_n low, synchronous) clears the line state and empties both
// output registers; no line is loaded afterward.
module line_pixel_generator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_x, start_y, end_x, end_y
  input  logic [lpg_pkg::IN_TDATA_W-1:0]    in_tdata,
  // kind
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pixel_x, pixel_y
  output logic [lpg_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);
  import lpg_pkg::*;

  localparam int C = COORD_BITS;

  logic [2:0]               zone_r, zone_nxt;
  logic [C-1:0]             walk_x_r, walk_x_nxt;
  logic [C-1:0]             walk_y_r, walk_y_nxt;
  logic [C-1:0]             stop_x_r, stop_x_nxt;
  logic signed [DEC_W-1:0]  decision_r, decision_nxt;
  logic signed [STEP_W-1:0] step_straight_r, step_straight_nxt;
  logic signed [STEP_W-1:0] step_diagonal_r, step_diagonal_nxt;
  logic                     active_r, active_nxt;

  pixel_t out_r, out_nxt, skid_r, skid_nxt, res;
  logic   out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic   in_fire, res_valid, fin;

  coord_t  sx, sy, ex, ey;
  wcoord_t dxt, dyt;
  logic [C:0] adx, ady;
  logic [2:0] zone_ld;
  wcoord_t a1, b1, a2, b2;
  logic signed [C+1:0] dx, dy;

  logic [C-1:0] na, nb;

  function automatic wcoord_t wext(input coord_t v);
    wext = {v[C-1], v};
  endfunction

  // true (x, y) to zone-0 (a, b), exact in one extra bit
  function automatic wcoord_t map_a(input logic [2:0] z, input coord_t x, input coord_t y);
    unique case (z) inside
      ZONE_0, ZONE_7: map_a = wext(x);
      ZONE_1, ZONE_2: map_a = wext(y);
      ZONE_3, ZONE_4: map_a = -wext(x);
      default:        map_a = -wext(y);
    endcase
  endfunction

  function automatic wcoord_t map_b(input logic [2:0] z, input coord_t x, input coord_t y);
    unique case (z) inside
      ZONE_0, ZONE_3: map_b = wext(y);
      ZONE_1, ZONE_6: map_b = wext(x);
      ZONE_2, ZONE_5: map_b = -wext(x);
      default:        map_b = -wext(y);
    endcase
  endfunction

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;

  assign sx = in_tdata[C-1:0];
  assign sy = in_tdata[2*C-1:C];
  assign ex = in_tdata[3*C-1:2*C];
  assign ey = in_tdata[4*C-1:3*C];

  always_comb begin
    dxt = wext(ex) - wext(sx);
    dyt = wext(ey) - wext(sy);
    adx = dxt[C] ? (C+1)'(0) - dxt : dxt;
    ady = dyt[C] ? (C+1)'(0) - dyt : dyt;
    // first matching sign pair wins, both deltas zero land in zone 0
    if (!dxt[C] && !dyt[C]) begin
      zone_ld = (adx >= ady) ? ZONE_0 : ZONE_1;
    end else if ((dxt[C] || dxt == '0) && !dyt[C]) begin
      zone_ld = (ady >= adx) ? ZONE_2 : ZONE_3;
    end else if ((dxt[C] || dxt == '0) && (dyt[C] || dyt == '0)) begin
      zone_ld = (adx >= ady) ? ZONE_4 : ZONE_5;
    end else begin
      zone_ld = (ady >= adx) ? ZONE_6 : ZONE_7;
    end
    a1 = map_a(zone_ld, sx, sy);
    b1 = map_b(zone_ld, sx, sy);
    a2 = map_a(zone_ld, ex, ey);
    b2 = map_b(zone_ld, ex, ey);
    dx = {a2[C], a2} - {a1[C], a1};
    dy = {b2[C], b2} - {b1[C], b1};
  end

  // current pixel mapped back to its true zone, modulo 2^C
  always_comb begin
    na = C'(0) - walk_x_r;
    nb = C'(0) - walk_y_r;
    fin = (walk_x_r == stop_x_r);
    res.last = fin;
    unique case (zone_r)
      ZONE_0: begin res.pixel_x = walk_x_r; res.pixel_y = walk_y_r; end
      ZONE_1: begin res.pixel_x = walk_y_r; res.pixel_y = walk_x_r; end
      ZONE_2: begin res.pixel_x = nb;       res.pixel_y = walk_x_r; end
      ZONE_3: begin res.pixel_x = na;       res.pixel_y = walk_y_r; end
      ZONE_4: begin res.pixel_x = na;       res.pixel_y = nb;       end
      ZONE_5: begin res.pixel_x = nb;       res.pixel_y = na;       end
      ZONE_6: begin res.pixel_x = walk_y_r; res.pixel_y = na;       end
      default: begin res.pixel_x = walk_x_r; res.pixel_y = nb;      end
    endcase
  end

  assign res_valid = in_fire && (in_tuser == KIND_STEP) && active_r;

  always_comb begin
    zone_nxt          = zone_r;
    walk_x_nxt        = walk_x_r;
    walk_y_nxt        = walk_y_r;
    stop_x_nxt        = stop_x_r;
    decision_nxt      = decision_r;
    step_straight_nxt = step_straight_r;
    step_diagonal_nxt = step_diagonal_r;
    active_nxt        = active_r;
    if (in_fire && in_tuser == KIND_LOAD) begin
      zone_nxt          = zone_ld;
      walk_x_nxt        = a1[C-1:0];
      walk_y_nxt        = b1[C-1:0];
      stop_x_nxt        = a2[C-1:0];
      decision_nxt      = (DEC_W'(dy) <<< 1) - DEC_W'(dx);
      step_straight_nxt = STEP_W'(dy) <<< 1;
      step_diagonal_nxt = (STEP_W'(dy) - STEP_W'(dx)) <<< 1;
      active_nxt        = 1'b1;
    end else if (res_valid) begin
      if (fin) begin
        active_nxt = 1'b0;
      end else begin
        if (decision_r < 0) begin
          decision_nxt = decision_r + DEC_W'(step_straight_r);
        end else begin
          walk_y_nxt   = walk_y_r + 1'b1;
          decision_nxt = decision_r + DEC_W'(step_diagonal_r);
        end
        walk_x_nxt = walk_x_r + 1'b1;
      end
    end
  end

  // output register with one skid slot behind it
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = res_valid;
      end
    end else if (res_valid) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r          <= '0;
      walk_x_r        <= '0;
      walk_y_r        <= '0;
      stop_x_r        <= '0;
      decision_r      <= '0;
      step_straight_r <= '0;
      step_diagonal_r <= '0;
      active_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      zone_r          <= zone_nxt;
      walk_x_r        <= walk_x_nxt;
      walk_y_r        <= walk_y_nxt;
      stop_x_r        <= stop_x_nxt;
      decision_r      <= decision_nxt;
      step_straight_r <= step_straight_nxt;
      step_diagonal_r <= step_diagonal_nxt;
      active_r        <= active_nxt;
      out_valid_r     <= out_valid_nxt;
      skid_valid_r    <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_r.pixel_y, out_r.pixel_x});
  assign out_tlast  = out_r.last;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full while output register empty");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && fin) |=> !active_r)
    else $error("line still active after its last pixel");

  a_load_starts_line: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == KIND_LOAD) |=> active_r)
    else $error("load word did not start a line");

  a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == KIND_STEP && !active_r && !out_valid_r) |=> !out_valid_r)
    else $error("step word with no line produced a pixel");
`endif

endmodule
